/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the antecedent implies the consequent in the same cycle
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/csem_pkg.sv */
// ----------------------------------------------------------------------------
// csem_pkg
// Types and constants shared by the semaphore controller and datapath.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int COUNT_W   = 16;
  localparam int INIT_W    = 15;
  localparam int ID_PORT_W = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_WAIT   = 2'd0,
    FUNC_SIGNAL = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_OPEN   = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BLOCKED = 2'd1,
    STAT_CLOSED  = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    open_load;   // reload count, reopen, empty queue
    logic    close_clear; // zero count, close, empty queue
    logic    dec_count;
    logic    sig_inc;     // saturating increment
    logic    enq;
    logic    deq;         // issue read at head and advance
    logic    emit;        // load result registers
    status_e status;
    logic    woken;       // result carries the id read from the queue
    logic    by_close;
    logic    last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_open;
    logic count_pos;
    logic queue_full;
    logic waiters_none;
    logic wake_on_signal;
  } dp_stat_t;

endpackage

/* src/csem_ram.sv */
// ----------------------------------------------------------------------------
// csem_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/csem_dp.sv */
// ----------------------------------------------------------------------------
// csem_dp
// Semaphore datapath: count, open flag, waiter queue and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csem_dp
  import csem_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [INIT_W-1:0]    initial_count_i,
  input  logic [ID_PORT_W-1:0] thread_id_i,
  input  cmd_t                 cmd_i,
  output dp_stat_t             stat_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic                 woken_valid_o,
  output logic [ID_PORT_W-1:0] woken_id_o,
  output logic                 woken_by_close_o,
  output logic                 last_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdW  = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  logic [INIT_W-1:0]         init_q;
  logic signed [COUNT_W-1:0] count_q, count_d, count_inc;
  logic                      open_q, open_d;
  logic [PtrW-1:0]           head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]           wcnt_q, wcnt_d;
  logic [IdW-1:0]            rdata;

  logic                      done_q;
  status_e                   status_q;
  logic                      wvalid_q, byclose_q, last_q;
  logic [ID_PORT_W-1:0]      wid_q;

  // Waiter id store
  csem_ram #(
    .WIDTH (IdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq),
    .waddr_i (tail_q),
    .wdata_i (thread_id_i[IdW-1:0]),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  // Saturating increment for signal
  assign count_inc = (count_q < COUNT_MAX) ? count_q + 16'sd1 : count_q;

  // Next count and open flag
  always_comb begin
    count_d = count_q;
    open_d  = open_q;
    if (cmd_i.open_load) begin
      count_d = signed'({1'b0, init_q});
      open_d  = 1'b1;
    end else if (cmd_i.close_clear) begin
      count_d = '0;
      open_d  = 1'b0;
    end else if (cmd_i.dec_count) begin
      count_d = count_q - 16'sd1;
    end else if (cmd_i.sig_inc) begin
      count_d = count_inc;
    end
  end

  // Next queue pointers and fill level
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    wcnt_d = wcnt_q;
    if (cmd_i.open_load || cmd_i.close_clear) begin
      head_d = '0;
      tail_d = '0;
      wcnt_d = '0;
    end else if (cmd_i.enq) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      wcnt_d = wcnt_q + 1'b1;
    end else if (cmd_i.deq) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      wcnt_d = wcnt_q - 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      count_q <= '0;
      open_q  <= 1'b1;
      head_q  <= '0;
      tail_q  <= '0;
      wcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= initial_count_i;
      end
      count_q <= count_d;
      open_q  <= open_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      wcnt_q  <= wcnt_d;
      done_q  <= cmd_i.emit;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= cmd_i.status;
      wvalid_q  <= cmd_i.woken;
      byclose_q <= cmd_i.by_close;
      last_q    <= cmd_i.last;
      wid_q     <= cmd_i.woken ? ID_PORT_W'(rdata) : '0;
    end
  end

  // Status towards the controller
  assign stat_o.is_open        = open_q;
  assign stat_o.count_pos      = (count_q > 16'sd0);
  assign stat_o.queue_full     = (wcnt_q >= CntFull);
  assign stat_o.waiters_none   = (wcnt_q == '0);
  assign stat_o.wake_on_signal = (count_inc <= 16'sd0) && (wcnt_q != '0);

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign woken_valid_o    = wvalid_q;
  assign woken_id_o       = wid_q;
  assign woken_by_close_o = byclose_q;
  assign last_o           = last_q;

  `ASSERT_ALWAYS(a_wcnt_bound, clk_i, rst_ni, wcnt_q <= CntFull, "waiter count overflow")
  `ASSERT_IMPLY(a_empty_ptrs, clk_i, rst_ni, wcnt_q == '0, head_q == tail_q, "empty queue ptrs differ")

endmodule

/* src/csem_ctrl.sv */
// ----------------------------------------------------------------------------
// csem_ctrl
// Semaphore controller: decodes operations and sequences queue reads.
// ----------------------------------------------------------------------------
module csem_ctrl
  import csem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  func_e    func_i,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o,
  output logic     busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Decode and sequence
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = STAT_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_OPEN) begin
            cmd_o.open_load = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.last      = 1'b1;
          end else if (!stat_i.is_open) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = STAT_CLOSED;
            cmd_o.last   = 1'b1;
          end else begin
            unique case (func_i)
              FUNC_WAIT: begin
                cmd_o.emit = 1'b1;
                cmd_o.last = 1'b1;
                if (stat_i.count_pos) begin
                  cmd_o.dec_count = 1'b1;
                end else if (stat_i.queue_full) begin
                  cmd_o.status = STAT_FULL;
                end else begin
                  cmd_o.dec_count = 1'b1;
                  cmd_o.enq       = 1'b1;
                  cmd_o.status    = STAT_BLOCKED;
                end
              end
              FUNC_SIGNAL: begin
                cmd_o.sig_inc = 1'b1;
                if (stat_i.wake_on_signal) begin
                  cmd_o.deq = 1'b1;
                  state_d   = ST_READ;
                end else begin
                  cmd_o.emit = 1'b1;
                  cmd_o.last = 1'b1;
                end
              end
              FUNC_CLOSE: begin
                if (stat_i.waiters_none) begin
                  cmd_o.close_clear = 1'b1;
                  cmd_o.emit        = 1'b1;
                  cmd_o.last        = 1'b1;
                end else begin
                  cmd_o.deq = 1'b1;
                  state_d   = ST_DRAIN;
                end
              end
              default: begin
                // open is handled above
              end
            endcase
          end
        end
      end
      ST_READ: begin
        // Hand out the waiter released by signal
        cmd_o.emit  = 1'b1;
        cmd_o.woken = 1'b1;
        cmd_o.last  = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_DRAIN: begin
        // Release one waiter per cycle, reading the next behind it
        cmd_o.emit     = 1'b1;
        cmd_o.woken    = 1'b1;
        cmd_o.by_close = 1'b1;
        if (stat_i.waiters_none) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.deq = 1'b1;
        end
      end
      ST_FINAL: begin
        cmd_o.close_clear = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.last        = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* src/counting_semaphore_fifo_waiters.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a FIFO of blocked thread ids.
// ----------------------------------------------------------------------------
// An operation is taken when start_i is high and busy_o is low. Its results
// appear one per cycle, each for a single cycle marked by done_o and each
// registered from the controller; the receiver cannot stall them and last_o flags
// the final one. Wait, open, errors, close on an empty queue and a signal that
// wakes nobody give one result in the cycle after the transfer and leave busy_o
// low, so such operations run one per cycle. A signal that wakes a waiter passes
// through ST_READ for the registered read of the waiter RAM, holding busy_o. Close
// with n waiters gives n+1 results and holds busy_o high while it issues them (one
// RAM read per waiter, then the final result). initial_count_i is loaded when
// cfg_we_i is high and takes effect on the next open.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module counting_semaphore_fifo_waiters
  import csem_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [INIT_W-1:0]    initial_count_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic [ID_PORT_W-1:0] thread_id_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic                 woken_valid_o,
  output logic [ID_PORT_W-1:0] woken_id_o,
  output logic                 woken_by_close_o,
  output logic                 last_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  csem_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_e'(func_i)),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  csem_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .initial_count_i  (initial_count_i),
    .thread_id_i      (thread_id_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .woken_valid_o    (woken_valid_o),
    .woken_id_o       (woken_id_o),
    .woken_by_close_o (woken_by_close_o),
    .last_o           (last_o)
  );

  `ASSERT_IMPLY(a_last_idle, clk_i, rst_ni, done_o && last_o, !busy_o, "last result while busy")
  `ASSERT_IMPLY(a_mid_busy, clk_i, rst_ni, done_o && !last_o, busy_o, "partial result while idle")
  `ASSERT_IMPLY(a_close_woken, clk_i, rst_ni, done_o && woken_by_close_o, woken_valid_o, "close wake without id")

endmodule
